### rtl/asde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asde_pkg
// Types, opcodes and function codes shared by the Alpha subset decode/execute
// block and its channel interfaces.
// ----------------------------------------------------------------------------
package asde_pkg;

  localparam logic [4:0] REG_NONE = 5'd31;

  localparam logic [3:0] SIZE_BYTE = 4'd1;
  localparam logic [3:0] SIZE_LONG = 4'd4;
  localparam logic [3:0] SIZE_QUAD = 4'd8;

  typedef enum logic [5:0] {
    OPC_LDA   = 6'h08,
    OPC_LDAH  = 6'h09,
    OPC_LDBU  = 6'h0A,
    OPC_LDQ_U = 6'h0B,
    OPC_STB   = 6'h0E,
    OPC_INTA  = 6'h10,
    OPC_INTL  = 6'h11,
    OPC_LDQ   = 6'h29,
    OPC_STL   = 6'h2C,
    OPC_BEQ   = 6'h39,
    OPC_BNE   = 6'h3D
  } asde_opc_e;

  localparam logic [6:0] FN_ADDL   = 7'h00;
  localparam logic [6:0] FN_CMPULT = 7'h1D;
  localparam logic [6:0] FN_ADDQ   = 7'h20;
  localparam logic [6:0] FN_S4ADDQ = 7'h22;
  localparam logic [6:0] FN_CMPEQ  = 7'h2D;
  localparam logic [6:0] FN_BIS    = 7'h20;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_BRANCH = 2'd3
  } asde_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EA,
    OP_EA_ALIGN,
    OP_BIS,
    OP_ADDQ,
    OP_ADDL,
    OP_CMPEQ,
    OP_S4ADDQ,
    OP_CMPULT,
    OP_BEQ,
    OP_BNE
  } asde_op_e;

  typedef struct packed {
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic        use_lit;
    logic [7:0]  lit;
    asde_kind_e  kind;
    logic [3:0]  size;
    asde_op_e    op;
    logic        fatal;
    logic [63:0] offset;
    logic [23:0] br_term;
  } asde_dec_t;

endpackage

### rtl/asde_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asde_if
// Valid/ready channels: instruction input and decode/execute result output.
// ----------------------------------------------------------------------------
interface asde_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] inst_address;
  logic [31:0] inst_word;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, inst_address, inst_word, operand_a, operand_b,
                  input ready);
  modport sink (input valid, inst_address, inst_word, operand_a, operand_b,
                output ready);
endinterface

interface asde_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_register;
  logic [4:0]  src_register_a;
  logic [4:0]  src_register_b;
  logic        b_uses_literal;
  logic [7:0]  literal_value;
  logic [1:0]  inst_kind;
  logic [3:0]  access_bytes;
  logic [63:0] result_value;
  logic [63:0] store_data;
  logic        br_taken;
  logic [63:0] br_target;
  logic        unimpl_trap;

  modport source (output valid, dest_register, src_register_a, src_register_b,
                  b_uses_literal, literal_value, inst_kind, access_bytes,
                  result_value, store_data, br_taken, br_target,
                  unimpl_trap,
                  input ready);
  modport sink (input valid, dest_register, src_register_a, src_register_b,
                b_uses_literal, literal_value, inst_kind, access_bytes,
                result_value, store_data, br_taken, br_target,
                unimpl_trap,
                output ready);
endinterface

### rtl/alpha_subset_decode_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_subset_decode_execute
// Decodes one Alpha integer instruction and executes a small subset of it.
//
// in_i carries one transaction per instruction: address, raw word and the
// two operand values chosen by the caller. out_o carries one transaction per
// instruction: register numbers, literal use, kind, access size, ALU result
// or effective address, store data, branch outcome and target, trap flag.
// Three register stages: input capture, decode, execute/output. out_o.valid
// rises once an accepted transaction has passed through the input capture,
// decode and output registers. Throughput is one transaction per cycle while
// out_o does not stall; the 64-bit adds and compares of the execute stage
// set the clock period.
// Each stage advances when it is empty or its successor advances, so a stall
// on out_o backs up stage by stage and in_i.ready falls only once all three
// stages hold data. Nothing is dropped or repeated.
// Reset empties all stages; in_i.ready is high right after reset.
// ----------------------------------------------------------------------------
module alpha_subset_decode_execute (
  input  logic              clk_i,
  input  logic              rst_ni,
  asde_in_if.sink           in_i,
  asde_out_if.source        out_o
);

  // stage enables
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // stage 1: input capture
  logic [63:0] s1_addr_q, s1_a_q, s1_b_q;
  logic [31:0] s1_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_addr_q <= in_i.inst_address;
      s1_word_q <= in_i.inst_word;
      s1_a_q    <= in_i.operand_a;
      s1_b_q    <= in_i.operand_b;
    end
  end

  // decode
  asde_pkg::asde_dec_t dec_d;
  asde_pkg::asde_opc_e opc;
  logic [4:0]  ra, rb, rc;
  logic [6:0]  fn;
  logic [15:0] mdisp;
  logic [21:0] br_sum;

  assign opc    = asde_pkg::asde_opc_e'(s1_word_q[31:26]);
  assign ra     = s1_word_q[25:21];
  assign rb     = s1_word_q[20:16];
  assign rc     = s1_word_q[4:0];
  assign fn     = s1_word_q[11:5];
  assign mdisp  = s1_word_q[15:0];
  assign br_sum = {s1_word_q[20], s1_word_q[20:0]} + 22'd1;

  always_comb begin
    dec_d         = '0;
    dec_d.dest    = asde_pkg::REG_NONE;
    dec_d.src_a   = asde_pkg::REG_NONE;
    dec_d.src_b   = asde_pkg::REG_NONE;
    dec_d.use_lit = 1'b0;
    dec_d.lit     = s1_word_q[20:13];
    dec_d.kind    = asde_pkg::KIND_OTHER;
    dec_d.size    = asde_pkg::SIZE_BYTE;
    dec_d.op      = asde_pkg::OP_NONE;
    dec_d.fatal   = 1'b0;
    dec_d.offset  = {{48{mdisp[15]}}, mdisp};
    dec_d.br_term = {br_sum, 2'b00};
    case (opc)
      asde_pkg::OPC_LDQ, asde_pkg::OPC_LDQ_U, asde_pkg::OPC_LDBU,
      asde_pkg::OPC_LDA, asde_pkg::OPC_LDAH: begin
        dec_d.src_a = rb;
        dec_d.dest  = ra;
        dec_d.op    = asde_pkg::OP_EA;
        if (opc == asde_pkg::OPC_LDQ || opc == asde_pkg::OPC_LDQ_U) begin
          dec_d.size = asde_pkg::SIZE_QUAD;
        end
        if (opc != asde_pkg::OPC_LDA && opc != asde_pkg::OPC_LDAH &&
            ra != asde_pkg::REG_NONE) begin
          dec_d.kind = asde_pkg::KIND_LOAD;
        end
        if (opc == asde_pkg::OPC_LDAH) begin
          dec_d.offset = {{32{mdisp[15]}}, mdisp, 16'h0000};
        end
        if (opc == asde_pkg::OPC_LDQ_U) begin
          dec_d.op = asde_pkg::OP_EA_ALIGN;
        end
      end
      asde_pkg::OPC_STL, asde_pkg::OPC_STB: begin
        dec_d.kind  = asde_pkg::KIND_STORE;
        dec_d.src_a = rb;
        dec_d.src_b = ra;
        dec_d.op    = asde_pkg::OP_EA;
        if (opc == asde_pkg::OPC_STL) begin
          dec_d.size = asde_pkg::SIZE_LONG;
        end
      end
      asde_pkg::OPC_INTA: begin
        dec_d.use_lit = s1_word_q[12];
        dec_d.dest    = rc;
        dec_d.src_a   = ra;
        dec_d.src_b   = rb;
        case (fn)
          asde_pkg::FN_ADDQ:   dec_d.op = asde_pkg::OP_ADDQ;
          asde_pkg::FN_ADDL:   dec_d.op = asde_pkg::OP_ADDL;
          asde_pkg::FN_CMPEQ:  dec_d.op = asde_pkg::OP_CMPEQ;
          asde_pkg::FN_S4ADDQ: dec_d.op = asde_pkg::OP_S4ADDQ;
          asde_pkg::FN_CMPULT: dec_d.op = asde_pkg::OP_CMPULT;
          default:             dec_d.fatal = 1'b1;
        endcase
      end
      asde_pkg::OPC_INTL: begin
        dec_d.use_lit = s1_word_q[12];
        dec_d.dest    = rc;
        dec_d.src_a   = ra;
        dec_d.src_b   = rb;
        if (fn == asde_pkg::FN_BIS) begin
          dec_d.op = asde_pkg::OP_BIS;
        end else begin
          dec_d.fatal = 1'b1;
        end
      end
      asde_pkg::OPC_BEQ, asde_pkg::OPC_BNE: begin
        dec_d.kind  = asde_pkg::KIND_BRANCH;
        dec_d.src_a = ra;
        dec_d.op    = (opc == asde_pkg::OPC_BEQ) ? asde_pkg::OP_BEQ : asde_pkg::OP_BNE;
      end
      default: begin
        dec_d.fatal = 1'b1;
      end
    endcase
  end

  // stage 2: decoded instruction
  asde_pkg::asde_dec_t s2_dec_q;
  logic [63:0] s2_addr_q, s2_a_q, s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_dec_q  <= dec_d;
      s2_addr_q <= s1_addr_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
    end
  end

  // execute
  logic [63:0] ea, sum_ab, res_d, target_d, sdata_d;
  logic        taken_d;

  assign ea     = s2_a_q + s2_dec_q.offset;
  assign sum_ab = s2_a_q + s2_b_q;

  always_comb begin
    res_d   = '0;
    taken_d = 1'b0;
    case (s2_dec_q.op)
      asde_pkg::OP_EA:       res_d = ea;
      asde_pkg::OP_EA_ALIGN: res_d = ea & ~64'd7;
      asde_pkg::OP_BIS:      res_d = s2_a_q | s2_b_q;
      asde_pkg::OP_ADDQ:     res_d = sum_ab;
      asde_pkg::OP_ADDL:     res_d = {{32{sum_ab[31]}}, sum_ab[31:0]};
      asde_pkg::OP_CMPEQ:    res_d = {63'd0, s2_a_q == s2_b_q};
      asde_pkg::OP_S4ADDQ:   res_d = {s2_a_q[61:0], 2'b00} + s2_b_q;
      asde_pkg::OP_CMPULT:   res_d = {63'd0, s2_a_q < s2_b_q};
      asde_pkg::OP_BEQ:      taken_d = (s2_a_q == 64'd0);
      asde_pkg::OP_BNE:      taken_d = (s2_a_q != 64'd0);
      default:               res_d = '0;
    endcase
  end

  assign target_d = (s2_dec_q.kind == asde_pkg::KIND_BRANCH) ?
                    s2_addr_q + {{40{s2_dec_q.br_term[23]}}, s2_dec_q.br_term} : 64'd0;
  assign sdata_d  = (s2_dec_q.kind == asde_pkg::KIND_STORE) ? s2_b_q : 64'd0;

  // stage 3: output register
  asde_pkg::asde_dec_t s3_dec_q;
  logic [63:0] s3_res_q, s3_sdata_q, s3_target_q;
  logic        s3_taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      s3_dec_q    <= s2_dec_q;
      s3_res_q    <= res_d;
      s3_sdata_q  <= sdata_d;
      s3_target_q <= target_d;
      s3_taken_q  <= taken_d;
    end
  end

  assign out_o.valid          = v3_q;
  assign out_o.dest_register  = s3_dec_q.dest;
  assign out_o.src_register_a = s3_dec_q.src_a;
  assign out_o.src_register_b = s3_dec_q.src_b;
  assign out_o.b_uses_literal = s3_dec_q.use_lit;
  assign out_o.literal_value  = s3_dec_q.lit;
  assign out_o.inst_kind      = s3_dec_q.kind;
  assign out_o.access_bytes   = s3_dec_q.size;
  assign out_o.result_value   = s3_res_q;
  assign out_o.store_data     = s3_sdata_q;
  assign out_o.br_taken       = s3_taken_q;
  assign out_o.br_target      = s3_target_q;
  assign out_o.unimpl_trap    = s3_dec_q.fatal;

  // assertions
  a_fatal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_dec_q.fatal |-> s3_res_q == 64'd0 && !s3_taken_q)
    else $error("fatal transaction with nonzero result");

  a_nonbranch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_dec_q.kind != asde_pkg::KIND_BRANCH |-> s3_target_q == 64'd0 && !s3_taken_q)
    else $error("branch outputs set on non-branch");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && $stable(s2_dec_q) && $stable(s2_a_q))
    else $error("decode stage lost data during stall");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en2 |=> v1_q && $stable(s1_word_q))
    else $error("input stage lost data during stall");

endmodule
